/* hw/rtl/key_interning_id_table_defines.svh */
// ----------------------------------------------------------------------------
// key_interning_id_table_defines
// Assertion macros for the key interning id table; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef KEY_INTERNING_ID_TABLE_DEFINES_SVH
`define KEY_INTERNING_ID_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define KIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define KIT_ASSERT(lbl, prop, msg)
`define KIT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/kit_pkg.sv */
// ----------------------------------------------------------------------------
// kit_pkg
// Shared constants and types of the key interning id table.
// ----------------------------------------------------------------------------
package kit_pkg;

	localparam int MAX_IDS  = 1024;
	localparam int ID_W     = (MAX_IDS > 2) ? $clog2(MAX_IDS) : 1;
	localparam int CNT_W    = $clog2(MAX_IDS + 1);
	localparam int OUT_ID_W = 10;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	// classified action
	typedef enum logic [1:0] {
		OP_INTERN      = 2'd0,
		OP_INTERN_ZERO = 2'd1,
		OP_REG         = 2'd2,
		OP_REG_BAD     = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] mask;
		logic [31:0] tag;
	} item_t;

	typedef struct packed {
		logic        present;
		logic [63:0] mask;
		logic [31:0] tag;
	} entry_t;

endpackage

/* hw/rtl/kit_front.sv */
// ----------------------------------------------------------------------------
// kit_front
// Accepts items, classifies the action and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module kit_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [63:0]         mask,
	input  logic [31:0]         type_code,
	input  logic                bad_descriptor,
	output logic                q_valid,
	output kit_pkg::item_t      q_item,
	input  logic                q_pop
);
	import kit_pkg::*;

	item_t      buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.mask = mask;
		cls.tag  = type_code;
		if (action) begin
			cls.op = bad_descriptor ? OP_REG_BAD : OP_REG;
		end else begin
			cls.op = (mask == 64'd0 && type_code == 32'd0) ? OP_INTERN_ZERO : OP_INTERN;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

/* hw/rtl/kit_back.sv */
// ----------------------------------------------------------------------------
// kit_back
// Executes queued actions: key memory scan, id allocation, result register.
// ----------------------------------------------------------------------------
module kit_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  kit_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kit_pkg::OUT_ID_W-1:0]  layout_id,
	output logic [1:0]                    status,
	output logic [kit_pkg::CNT_W-1:0]     next_id
);
	import kit_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t             state_q;
	item_t              cur_q;
	logic [CNT_W-1:0]   issue_q;
	logic               pend_v_q;
	logic [CNT_W-1:0]   pend_id_q;
	logic [CNT_W-1:0]   next_q;
	logic [CNT_W-1:0]   res_id_q;
	logic [1:0]         res_st_q;
	entry_t             mem [MAX_IDS];
	entry_t             rd_q;

	logic               full;
	logic               issue_more;
	logic               match;
	logic               out_free;
	logic               we;
	entry_t             wd;

	assign next_id    = next_q;
	assign full       = (next_q == CNT_W'(MAX_IDS));
	assign issue_more = (issue_q < next_q);
	assign match      = pend_v_q && rd_q.present && rd_q.mask == cur_q.mask
	                    && rd_q.tag == cur_q.tag;
	assign out_free   = !out_valid || !out_stall;
	assign q_pop      = (state_q == S_IDLE) && q_valid;

	always_comb begin
		we = 1'b0;
		if (state_q == S_IDLE && q_valid && !full) begin
			we = (q_item.op == OP_REG) ||
			     (q_item.op == OP_INTERN && next_q == CNT_W'(1));
		end else if (state_q == S_SCAN && !issue_more && !match && !full) begin
			we = 1'b1;
		end
		if (state_q == S_SCAN) begin
			wd.present = 1'b1;
			wd.mask    = cur_q.mask;
			wd.tag     = cur_q.tag;
		end else begin
			wd.present = (q_item.op == OP_INTERN);
			wd.mask    = q_item.mask;
			wd.tag     = q_item.tag;
		end
	end

	// key memory, one read per cycle for the scan
	always_ff @(posedge clk) begin
		if (we) mem[next_q[ID_W-1:0]] <= wd;
		rd_q <= mem[issue_q[ID_W-1:0]];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					cur_q   <= q_item;
					issue_q <= CNT_W'(1);
					case (q_item.op)
						OP_REG_BAD: begin
							res_id_q <= '0;
							res_st_q <= ST_BAD;
						end
						OP_REG: begin
							res_id_q <= full ? '0 : next_q;
							res_st_q <= full ? ST_FULL : ST_NEW;
						end
						OP_INTERN_ZERO: begin
							res_id_q <= '0;
							res_st_q <= ST_FOUND;
						end
						default: begin
							res_id_q <= next_q;
							res_st_q <= ST_NEW;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (issue_more) issue_q <= issue_q + CNT_W'(1);
				pend_id_q <= issue_q;
				if (match) begin
					res_id_q <= pend_id_q;
					res_st_q <= ST_FOUND;
				end else if (!issue_more) begin
					res_id_q <= full ? '0 : next_q;
					res_st_q <= full ? ST_FULL : ST_NEW;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			layout_id <= OUT_ID_W'(res_id_q);
			status    <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			next_q    <= CNT_W'(1);
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					pend_v_q <= 1'b0;
					if (q_valid) begin
						if (we) next_q <= next_q + CNT_W'(1);
						if (q_item.op == OP_INTERN && next_q != CNT_W'(1)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					pend_v_q <= issue_more;
					if (match || !issue_more) begin
						if (we) next_q <= next_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/key_interning_id_table.sv */
// ----------------------------------------------------------------------------
// key_interning_id_table
// Interns (mask, type_code) keys into sequential layout ids.
// ----------------------------------------------------------------------------
// One result per transfer. A transfer passes through the queue; from the
// queue head, register actions, the all-zero key and an intern into an
// empty table go straight to the result register (pop, then load). An
// intern of any other key scans the key memory one entry per cycle over
// ids 1 .. next_free-1 and stops at the first match, as the key memory has
// a single read port. A two-entry queue lets the input keep taking
// transfers during a scan.
// No clearing pass after reset: only written entries are ever scanned.
// ----------------------------------------------------------------------------
`include "key_interning_id_table_defines.svh"

module key_interning_id_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [63:0]                   mask,
	input  logic [31:0]                   type_code,
	input  logic                          bad_descriptor,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kit_pkg::OUT_ID_W-1:0]  layout_id,
	output logic [1:0]                    status
);
	import kit_pkg::*;

	// front to back queue head
	logic              q_valid;
	logic              q_pop;
	item_t             q_item;
	logic [CNT_W-1:0]  next_id;
	logic              err_out;

	// front: classify and queue
	kit_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.mask           (mask),
		.type_code      (type_code),
		.bad_descriptor (bad_descriptor),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	// back: lookup, allocate, deliver
	kit_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.layout_id (layout_id),
		.status    (status),
		.next_id   (next_id)
	);

	// error results carry id zero
	assign err_out = (status == ST_FULL) || (status == ST_BAD);

	`KIT_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
	`KIT_ASSERT(a_next_bound, next_id <= CNT_W'(MAX_IDS), "next id past table size")
	`KIT_ASSERT(a_err_id_zero, out_valid && err_out |-> layout_id == '0, "error with nonzero id")
	`KIT_ASSERT_NEXT(a_next_step, 1'b1, next_id == $past(next_id) || next_id == $past(next_id) + CNT_W'(1), "next id jumped")

endmodule

/* tb/kit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kit_checker
// Watches both channels of the key interning id table, predicts each result
// from its own copy of the key store and compares in order.
// ----------------------------------------------------------------------------
module kit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [63:0] mask,
	input  logic [31:0] type_code,
	input  logic        bad_descriptor,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [9:0]  layout_id,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          full_seen
);
	import kit_pkg::*;

	typedef struct packed {
		logic [9:0] id;
		logic [1:0] st;
	} id_result_t;

	logic [63:0] key_mask [MAX_IDS];
	logic [31:0] key_tag  [MAX_IDS];
	bit          key_used [MAX_IDS];
	int          next_id;
	id_result_t  expected_ids [$];

	function automatic id_result_t intern_predict(logic act, logic [63:0] m,
		logic [31:0] tg, logic bad);
		id_result_t r;
		r = '0;
		if (act) begin
			if (bad) r.st = ST_BAD;
			else if (next_id >= MAX_IDS) r.st = ST_FULL;
			else begin
				r.id = next_id[9:0];
				r.st = ST_NEW;
				next_id++;
			end
			return r;
		end
		for (int i = 0; i < next_id && i < MAX_IDS; i++) begin
			if (key_used[i] && key_mask[i] == m && key_tag[i] == tg) begin
				r.id = i[9:0];
				r.st = ST_FOUND;
				return r;
			end
		end
		if (next_id >= MAX_IDS) begin
			r.st = ST_FULL;
			return r;
		end
		key_mask[next_id] = m;
		key_tag[next_id]  = tg;
		key_used[next_id] = 1'b1;
		r.id = next_id[9:0];
		r.st = ST_NEW;
		next_id++;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		results_seen = 0;
		full_seen = 0;
		for (int i = 0; i < MAX_IDS; i++) key_used[i] = 1'b0;
		key_used[0] = 1'b1;
		key_mask[0] = '0;
		key_tag[0]  = '0;
		next_id = 1;
	end

	always @(posedge clk) begin
		id_result_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_ids.push_back(intern_predict(action, mask, type_code,
					bad_descriptor));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (status == ST_FULL) full_seen++;
				if (expected_ids.size() == 0) begin
					$display("%0t: unexpected result id=%0d status=%0d",
						$time, layout_id, status);
					fail_count++;
				end else begin
					e = expected_ids.pop_front();
					if (e.id !== layout_id) begin
						$display("%0t: layout_id expected %0d actual %0d",
							$time, e.id, layout_id);
						fail_count++;
					end
					if (e.st !== status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, e.st, status);
						fail_count++;
					end
				end
			end
			pending = expected_ids.size();
		end
	end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the key interning id table: directed keys, a
// random mix of repeats and fresh keys that fills the table with random
// idle and stall bursts on both sides, then traffic against a full table.
// ----------------------------------------------------------------------------
module tb;
	import kit_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [63:0] mask;
	logic [31:0] type_code;
	logic        bad_descriptor;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  layout_id;
	logic [1:0]  status;
	int          fail_count;
	int          pending;
	int          results_seen;
	int          full_seen;

	// keys sent so far, so repeats hit stored entries
	logic [63:0] sent_mask [$];
	logic [31:0] sent_tag  [$];
	bit          quiet;     // no idling in the last part of the run
	int          n_sent;

	localparam logic ACT_INTERN   = 1'b0;
	localparam logic ACT_REGISTER = 1'b1;

	key_interning_id_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .mask(mask), .type_code(type_code),
		.bad_descriptor(bad_descriptor),
		.out_valid(out_valid), .out_stall(out_stall),
		.layout_id(layout_id), .status(status)
	);

	kit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .mask(mask), .type_code(type_code),
		.bad_descriptor(bad_descriptor),
		.out_valid(out_valid), .out_stall(out_stall),
		.layout_id(layout_id), .status(status),
		.fail_count(fail_count), .pending(pending),
		.results_seen(results_seen), .full_seen(full_seen)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Present one transfer at the falling edge, hold it until accepted,
	// then maybe insert an idle burst.
	task automatic send_item(logic act, logic [63:0] m, logic [31:0] tg, logic bad);
		int gap;
		in_valid       <= 1'b1;
		action         <= act;
		mask           <= m;
		type_code      <= tg;
		bad_descriptor <= bad;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		n_sent++;
		if (act == ACT_INTERN) begin
			sent_mask.push_back(m);
			sent_tag.push_back(tg);
		end
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Random intern/register mix; repeats favor previously sent keys.
	task automatic random_item();
		int k;
		int sel;
		logic [63:0] m;
		logic [31:0] tg;
		sel = $urandom_range(0, 99);
		m = {$urandom, $urandom};
		tg = $urandom;
		if (sel < 15)
			send_item(ACT_REGISTER, m, tg, $urandom_range(0, 3) == 0);
		else if (sel < 45 && sent_mask.size() > 0) begin
			k = $urandom_range(0, sent_mask.size() - 1);
			send_item(ACT_INTERN, sent_mask[k], sent_tag[k], 1'($urandom_range(0, 1)));
		end else if (sel < 55) begin
			// near misses: one bit off a known key
			k = $urandom_range(0, sent_mask.size() - 1);
			if (sel < 50) send_item(ACT_INTERN, sent_mask[k] ^ (64'd1 << $urandom_range(0, 63)),
				sent_tag[k], 1'b0);
			else send_item(ACT_INTERN, sent_mask[k], sent_tag[k] ^ (32'd1 << $urandom_range(0, 31)),
				1'b0);
		end else
			send_item(ACT_INTERN, m, tg, 1'($urandom_range(0, 1)));
	endtask

	// Output stall bursts, none once the run goes quiet
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int waited;
		in_valid = 1'b0;
		action = ACT_INTERN;
		mask = '0;
		type_code = '0;
		bad_descriptor = 1'b0;
		quiet = 1'b0;
		n_sent = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero key, field extremes, register cases, repeats
		send_item(ACT_INTERN, '0, '0, 1'b0);
		send_item(ACT_INTERN, '1, '1, 1'b0);
		send_item(ACT_INTERN, '1, '1, 1'b1);
		send_item(ACT_INTERN, '0, 32'd1, 1'b0);
		send_item(ACT_INTERN, 64'd1, '0, 1'b0);
		send_item(ACT_INTERN, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0);
		send_item(ACT_INTERN, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_item(ACT_INTERN, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0);
		send_item(ACT_REGISTER, '0, '0, 1'b0);
		send_item(ACT_REGISTER, '1, '1, 1'b1);
		send_item(ACT_REGISTER, '1, '1, 1'b0);
		send_item(ACT_INTERN, '0, '0, 1'b1);
		send_item(ACT_INTERN, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_item(ACT_INTERN, '0, 32'd1, 1'b0);

		// random mix until the table is full, then more against a full table
		repeat (1400) random_item();
		quiet = 1'b1;
		repeat (150) random_item();
		in_valid <= 1'b0;

		waited = 0;
		while (pending > 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (2 * MAX_IDS + 20) @(negedge clk);

		$display("sent %0d transfers, checked %0d results, %0d of them table full",
			n_sent, results_seen, full_seen);
		if (fail_count == 0 && pending == 0)
			$display("key_interning_id_table regression: pass");
		else
			$display("key_interning_id_table regression: fail");
		$finish;
	end

	// a scan can cover the whole table per item; allow ample margin
	initial begin
		#200ms;
		$display("key_interning_id_table regression: fail");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/kit_pkg.sv
hw/rtl/kit_front.sv
hw/rtl/kit_back.sv
hw/rtl/key_interning_id_table.sv
tb/kit_checker.sv
tb/tb.sv
